// File: rtl/core/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 38;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT   = 3'd0,
        CMD_INSERT_AFTER = 3'd1,
        CMD_APPEND       = 3'd2,
        CMD_POP_FRONT    = 3'd3,
        CMD_DELETE_KEY   = 3'd4,
        CMD_POP_BACK     = 3'd5,
        CMD_SEARCH       = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_UP_SETUP,
        OP_DOWN_SETUP,
        OP_SCAN_SETUP,
        OP_STEP_UP,
        OP_STEP_DOWN,
        OP_STEP_SCAN,
        OP_COMMIT_UP
    } dp_op_t;

    typedef enum logic [2:0] {
        POS_ZERO,
        POS_OCC,
        POS_LAST,
        POS_HIT,
        POS_HIT_NEXT
    } pos_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_FINISH
    } ctl_state_t;

    typedef struct packed {
        dp_op_t   op;
        pos_sel_t pos_sel;
        logic     commit_down;
        logic     capture;
        logic     note_en;
        status_t  note_status;
        logic     note_found;
        logic     result_load;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic hit;
        logic walk_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bounded_ordered_list_engine_top.sv
// Top level of the bounded ordered list engine.
//
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------
//  in       in_valid / in_ready    cmd[2:0], value[31:0] s, key[31:0] s
//  out      out_valid / out_ready  status[1:0], found, entry_count[6:0],
//                                  entry_sum[37:0] s
//
// One item at a time. Rejected and no-op commands take the shortest path; a key scan
// walks up to the hit (the whole list on a miss), an insert shift walks the moved entries
// and a delete shift walks from the slot to the end, so the worst case is any delete by
// key in a full list. Command length is set by the entry memory walk: at most one read
// and one write per cycle.
// Reset clears count and sum; the entry memory needs no clearing.
// A result waiting on out_ready does not block the next transaction until that
// transaction has its own result ready.
`default_nettype none

module bounded_ordered_list_engine_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        cmd,
    input  logic signed [bole_pkg::DATA_W-1:0] value,
    input  logic signed [bole_pkg::DATA_W-1:0] key,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic                              found,
    output logic [bole_pkg::CNT_W-1:0]        entry_count,
    output logic signed [bole_pkg::SUM_W-1:0] entry_sum
);
    import bole_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    bole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    bole_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (value),
        .key         (key),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .entry_count (entry_count),
        .entry_sum   (entry_sum)
    );

endmodule

`default_nettype wire

// File: rtl/core/bole_dp.sv
// Datapath: entry memory, walk pointer, count, sum and result register.
`default_nettype none

module bole_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [2:0]                        cmd,
    input  logic signed [bole_pkg::DATA_W-1:0] value,
    input  logic signed [bole_pkg::DATA_W-1:0] key,
    input  bole_pkg::ctl_cmd_t                ctl,
    output bole_pkg::dp_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic                              found,
    output logic [bole_pkg::CNT_W-1:0]        entry_count,
    output logic signed [bole_pkg::SUM_W-1:0] entry_sum
);
    import bole_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] key_reg;
    status_t           note_status_reg;
    logic              note_found_reg;

    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              vld_reg, vld_next;
    logic [IDX_W-1:0]  vaddr_reg, vaddr_next;

    logic              out_valid_reg;
    status_t           res_status_reg;
    logic              res_found_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic [SUM_W-1:0]  res_sum_reg;

    logic [CNT_W-1:0]  pos_pick;
    logic              re;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              issue;

    always_comb
    begin
        case (ctl.pos_sel)
            POS_ZERO:     pos_pick = '0;
            POS_OCC:      pos_pick = occ_reg;
            POS_LAST:     pos_pick = occ_reg - CNT_W'(1);
            POS_HIT:      pos_pick = CNT_W'(vaddr_reg);
            POS_HIT_NEXT: pos_pick = CNT_W'(vaddr_reg) + CNT_W'(1);
            default:      pos_pick = '0;
        endcase
    end

    assign issue = (cnt_reg != '0);

    always_comb
    begin
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        vld_next   = 1'b0;
        vaddr_next = vaddr_reg;
        occ_next   = occ_reg;
        sum_next   = sum_reg;
        re         = 1'b0;
        we         = 1'b0;
        waddr      = vaddr_reg;
        wdata      = rdata_reg;
        case (ctl.op)
            OP_UP_SETUP:
            begin
                pos_next = pos_pick;
                cnt_next = occ_reg - pos_pick;
                ptr_next = occ_reg - CNT_W'(1);
            end
            OP_DOWN_SETUP:
            begin
                pos_next = pos_pick;
                cnt_next = occ_reg - pos_pick;
                ptr_next = pos_pick;
            end
            OP_SCAN_SETUP:
            begin
                cnt_next = occ_reg;
                ptr_next = '0;
            end
            OP_STEP_UP:
            begin
                // reads walk from the back toward the slot, writes trail one place up
                if (issue)
                begin
                    re         = 1'b1;
                    vld_next   = 1'b1;
                    vaddr_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg - CNT_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
                if (vld_reg)
                begin
                    we    = 1'b1;
                    waddr = vaddr_reg + IDX_W'(1);
                end
            end
            OP_STEP_DOWN:
            begin
                if (issue)
                begin
                    re         = 1'b1;
                    vld_next   = 1'b1;
                    vaddr_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + CNT_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
                if (vld_reg)
                begin
                    // first read is the removed entry, the rest close the gap
                    if (CNT_W'(vaddr_reg) == pos_reg)
                    begin
                        sum_next = sum_reg - {{(SUM_W-DATA_W){rdata_reg[DATA_W-1]}}, rdata_reg};
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = vaddr_reg - IDX_W'(1);
                    end
                end
            end
            OP_STEP_SCAN:
            begin
                if (issue)
                begin
                    re         = 1'b1;
                    vld_next   = 1'b1;
                    vaddr_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + CNT_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
            end
            OP_COMMIT_UP:
            begin
                we       = 1'b1;
                waddr    = pos_reg[IDX_W-1:0];
                wdata    = value_reg;
                occ_next = occ_reg + CNT_W'(1);
                sum_next = sum_reg + {{(SUM_W-DATA_W){value_reg[DATA_W-1]}}, value_reg};
            end
            default:
            begin
            end
        endcase
        if (ctl.commit_down)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            sum_reg       <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            vld_reg       <= 1'b0;
            vaddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            sum_reg   <= sum_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            vld_reg   <= vld_next;
            vaddr_reg <= vaddr_next;
            if (ctl.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd_t'(cmd);
            value_reg <= value;
            key_reg   <= key;
        end
        if (ctl.note_en)
        begin
            note_status_reg <= ctl.note_status;
            note_found_reg  <= ctl.note_found;
        end
        if (ctl.result_load)
        begin
            res_status_reg <= note_status_reg;
            res_found_reg  <= note_found_reg;
            res_count_reg  <= occ_reg;
            res_sum_reg    <= sum_reg;
        end
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.full      = (occ_reg >= CNT_W'(CAPACITY));
        stat.empty     = (occ_reg == '0);
        stat.hit       = vld_reg && (rdata_reg == key_reg);
        stat.walk_done = (cnt_reg == '0) && !vld_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign found       = res_found_reg;
    assign entry_count = res_count_reg;
    assign entry_sum   = res_sum_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_commit_up_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_COMMIT_UP) |-> (occ_reg < CNT_W'(CAPACITY)))
        else $error("insert committed into a full list");

    a_commit_down_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit_down |-> (occ_reg != '0))
        else $error("delete committed on an empty list");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending transaction");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |=> (entry_count == $past(occ_reg)))
        else $error("reported count does not match list");

endmodule

`default_nettype wire

// File: rtl/core/bole_ctrl.sv
// Controller state machine: sequences decode, key scan, entry shifts and result hand-off.
`default_nettype none

module bole_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bole_pkg::dp_stat_t stat,
    output bole_pkg::ctl_cmd_t ctl
);
    import bole_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_PUSH_FRONT, CMD_APPEND:
                        state_next = stat.full ? S_FINISH : S_SHIFT_UP;
                    CMD_INSERT_AFTER:
                        state_next = stat.full ? S_FINISH : S_SCAN;
                    CMD_POP_FRONT, CMD_POP_BACK:
                        state_next = stat.empty ? S_FINISH : S_SHIFT_DOWN;
                    CMD_DELETE_KEY, CMD_SEARCH:
                        state_next = stat.empty ? S_FINISH : S_SCAN;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    case (stat.cmd)
                        CMD_INSERT_AFTER: state_next = S_SHIFT_UP;
                        CMD_DELETE_KEY:   state_next = S_SHIFT_DOWN;
                        default:          state_next = S_FINISH;
                    endcase
                end
                else if (stat.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP, S_SHIFT_DOWN:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl             = '0;
        ctl.op          = OP_HOLD;
        ctl.pos_sel     = POS_ZERO;
        ctl.note_status = ST_OK;
        in_ready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            S_DECODE:
            begin
                ctl.note_en = 1'b1;
                case (stat.cmd)
                    CMD_PUSH_FRONT, CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            ctl.note_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.op      = OP_UP_SETUP;
                            ctl.pos_sel = (stat.cmd == CMD_APPEND) ? POS_OCC : POS_ZERO;
                        end
                    end
                    CMD_INSERT_AFTER:
                    begin
                        if (stat.full)
                        begin
                            ctl.note_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.op = OP_SCAN_SETUP;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            ctl.note_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.op      = OP_DOWN_SETUP;
                            ctl.pos_sel = (stat.cmd == CMD_POP_BACK) ? POS_LAST : POS_ZERO;
                        end
                    end
                    CMD_DELETE_KEY, CMD_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            ctl.note_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.op = OP_SCAN_SETUP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    ctl.note_en    = 1'b1;
                    ctl.note_found = 1'b1;
                    case (stat.cmd)
                        CMD_INSERT_AFTER:
                        begin
                            ctl.op      = OP_UP_SETUP;
                            ctl.pos_sel = POS_HIT_NEXT;
                        end
                        CMD_DELETE_KEY:
                        begin
                            ctl.op      = OP_DOWN_SETUP;
                            ctl.pos_sel = POS_HIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (stat.walk_done)
                begin
                    ctl.note_en     = 1'b1;
                    ctl.note_status = ST_NOTFOUND;
                end
                else
                begin
                    ctl.op = OP_STEP_SCAN;
                end
            end
            S_SHIFT_UP:
            begin
                ctl.op = stat.walk_done ? OP_COMMIT_UP : OP_STEP_UP;
            end
            S_SHIFT_DOWN:
            begin
                if (stat.walk_done)
                begin
                    ctl.commit_down = 1'b1;
                end
                else
                begin
                    ctl.op = OP_STEP_DOWN;
                end
            end
            S_FINISH:
            begin
                ctl.result_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
